### hdl/lp2c_pkg.sv
// ----------------------------------------------------------------------------
// lp2c_pkg: shared types and constants
// Sequencer states, tag characters and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package lp2c_pkg;

  localparam int unsigned COUNT_W = 24;
  localparam int unsigned POS_W   = 25;
  localparam int unsigned ANG_W   = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;
  localparam logic [COUNT_W-1:0] THRESH_RESET = 24'd1000;
  localparam logic signed [19:0] GAIN_Q16 = 20'sd39797;
  localparam logic [19:0] CD_TO_RAD = 20'd749613;
  localparam logic [7:0] CHAR_E = 8'h45;

  typedef enum logic [1:0] {
    HDR_FIRST = 2'd0,
    HDR_TAG   = 2'd1,
    HDR_REC   = 2'd2,
    HDR_DROP  = 2'd3
  } hdr_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_THETA,
    ST_CORDIC,
    ST_QUAD,
    ST_MUL_RC,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_EMIT_PT,
    ST_EMIT_MK
  } seq_state_t;

  typedef enum logic [2:0] {C_IDLE, C_RED, C_TH, C_ROT, C_FIN} cordic_state_t;

  function automatic logic [7:0] tag_char(input logic [2:0] idx);
    case (idx)
      3'd0: tag_char = 8'h45;
      3'd1: tag_char = 8'h42;
      3'd2: tag_char = 8'h52;
      3'd3: tag_char = 8'h42;
      3'd4: tag_char = 8'h45;
      3'd5: tag_char = 8'h50;
      default: tag_char = 8'h00;
    endcase
  endfunction

  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    case (i)
      5'd0: atan_q16 = 17'd51472;
      5'd1: atan_q16 = 17'd30386;
      5'd2: atan_q16 = 17'd16055;
      5'd3: atan_q16 = 17'd8150;
      5'd4: atan_q16 = 17'd4091;
      5'd5: atan_q16 = 17'd2047;
      5'd6: atan_q16 = 17'd1024;
      5'd7: atan_q16 = 17'd512;
      5'd8: atan_q16 = 17'd256;
      5'd9: atan_q16 = 17'd128;
      5'd10: atan_q16 = 17'd64;
      5'd11: atan_q16 = 17'd32;
      5'd12: atan_q16 = 17'd16;
      5'd13: atan_q16 = 17'd8;
      5'd14: atan_q16 = 17'd4;
      5'd15: atan_q16 = 17'd2;
      5'd16: atan_q16 = 17'd1;
      default: atan_q16 = 17'd0;
    endcase
  endfunction

endpackage

### hdl/lp2c_cordic.sv
// ----------------------------------------------------------------------------
// lp2c_cordic: iterative sine/cosine
// One rotation step per cycle; Q16 sine and cosine of an angle in [0,36000)
// centidegrees, quadrant folded at the end.
// ----------------------------------------------------------------------------
module lp2c_cordic import lp2c_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [ANG_W-1:0]    angle,
  output logic                done,
  output logic signed [19:0]  sin_out,
  output logic signed [19:0]  cos_out
);

  localparam int unsigned IW = $clog2(CORDIC_STEPS + 1);

  cordic_state_t cst_r, cst_nxt;
  logic [ANG_W-1:0] a_r;
  logic [1:0] q_r;
  logic signed [20:0] x_r, y_r;
  logic signed [20:0] z_r;
  logic [IW-1:0] i_r;
  logic signed [20:0] dx, dy;
  logic [4:0] idx5;
  logic [34:0] prod;

  assign idx5 = 5'(i_r);
  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign prod = 35'(a_r[13:0]) * 35'(CD_TO_RAD) + 35'd32768;

  always_comb begin
    cst_nxt = cst_r;
    case (cst_r)
      C_IDLE: if (start) cst_nxt = C_RED;
      C_RED: if (a_r < 16'd9000) cst_nxt = C_TH;
      C_TH: cst_nxt = C_ROT;
      C_ROT: if (i_r == IW'(CORDIC_STEPS - 1)) cst_nxt = C_FIN;
      C_FIN: cst_nxt = C_IDLE;
      default: cst_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cst_r <= C_IDLE;
    else cst_r <= cst_nxt;
  end

  // Reduce by repeated subtraction of 9000 after one wrap of 36000.
  always_ff @(posedge clk) begin
    case (cst_r)
      C_IDLE: if (start) begin
        a_r <= (angle >= 16'd36000) ? angle - 16'd36000 : angle;
        q_r <= 2'd0;
      end
      C_RED: if (a_r >= 16'd9000) begin
        a_r <= a_r - 16'd9000;
        q_r <= q_r + 2'd1;
      end
      C_TH: begin
        z_r <= 21'(prod[34:16]);
        x_r <= 21'(GAIN_Q16);
        y_r <= '0;
        i_r <= '0;
      end
      C_ROT: begin
        if (!z_r[20]) begin
          x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - 21'(atan_q16(idx5));
        end else begin
          x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + 21'(atan_q16(idx5));
        end
        i_r <= i_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign done = (cst_r == C_FIN);

  always_comb begin
    case (q_r)
      2'd0: begin sin_out = 20'(y_r);  cos_out = 20'(x_r);  end
      2'd1: begin sin_out = 20'(x_r);  cos_out = 20'(-y_r); end
      2'd2: begin sin_out = 20'(-y_r); cos_out = 20'(-x_r); end
      default: begin sin_out = 20'(-x_r); cos_out = 20'(y_r); end
    endcase
  end

`ifndef SYNTHESIS
  a_reduce_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cst_r == C_TH |-> a_r < 16'd9000) else $error("angle not reduced");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("done held");
  a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
    cst_r == C_ROT |-> i_r < IW'(CORDIC_STEPS)) else $error("iteration overrun");
`endif

endmodule

### hdl/lidar_packet_to_cartesian_points_unit.sv
// ----------------------------------------------------------------------------
// lidar_packet_to_cartesian_points_unit: packet bytes to Cartesian points
// Parses the scanner packet, converts each 8-byte record with a shared
// CORDIC and one shared multiplier, and emits points and cloud markers.
// ----------------------------------------------------------------------------
//  channel | direction | beat contents
//  in_     | input     | byte_value, last_byte
//  out_    | output    | kind, x/y/z_pos, intensity, cloud_points, run_last
//  cfg_    | input     | cloud_threshold write data
//
// A header or mid-record byte is taken at once; a byte that only closes a
// cloud is followed by a marker beat. For the byte closing a record the
// CORDIC runs once for azimuth and once for elevation (each with quadrant
// reduction), then four multiplies share one multiplier, and a marker beat
// follows the point when that byte also closes a cloud.
// Reset (rst_n low, synchronous) clears parser and count, sets THRESH_RESET.
// in_ready drops while a byte is being worked on or a beat waits; a stalled
// out_ holds it.
// ----------------------------------------------------------------------------
module lidar_packet_to_cartesian_points_unit import lp2c_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 2048,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte_value,
  input  logic                     in_last_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_kind,
  output logic signed [POS_W-1:0]  out_x_pos,
  output logic signed [POS_W-1:0]  out_y_pos,
  output logic signed [POS_W-1:0]  out_z_pos,
  output logic [15:0]              out_intensity,
  output logic [COUNT_W-1:0]       out_cloud_points,
  output logic                     out_run_last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [COUNT_W-1:0]       cfg_cloud_threshold
);

  localparam int unsigned PW = $clog2(MAX_PACKET_BYTES + 1);

  seq_state_t st_r, st_nxt;
  hdr_mode_t mode_r;
  logic [PW-1:0] pos_r;
  logic [7:0] rec_r [7];
  logic [2:0] fill_r;
  logic [COUNT_W-1:0] count_r, thresh_r;
  logic [7:0] lastb_r;
  logic mk_r;
  logic el_pass_r;
  logic signed [19:0] sa_r, ca_r, se_r, ce_r;
  logic signed [36:0] rc_r;
  logic signed [56:0] mul_res;
  logic signed [36:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [POS_W-1:0] x_r, y_r, z_r;
  logic cstart, cdone;
  logic [ANG_W-1:0] cangle;
  logic signed [19:0] csin, ccos;
  logic in_fire, out_fire;
  logic signed [15:0] el_s, r_s;
  logic [16:0] el_off;
  logic valid_end;
  logic nx_pt, nx_mk;
  hdr_mode_t nx_mode;
  logic [PW-1:0] nx_pos;
  logic [2:0] nx_fill;
  logic [COUNT_W-1:0] cnt_after;
  logic mk_only_r;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  // Hold the input while a marker-only beat waits on the output.
  assign in_ready = (st_r == ST_IDLE) && !mk_only_r;
  assign cfg_ready = 1'b1;

  assign el_s = {rec_r[2], rec_r[3]};
  assign r_s  = {rec_r[4], rec_r[5]};
  // Elevation + 36000 lands in [3232, 68767]; one 36000 is taken off below.
  assign el_off = 17'(signed'({{1{el_s[15]}}, el_s}) + 17'sd36000);

  always_comb begin
    if (!el_pass_r) cangle = {rec_r[0], rec_r[1]};
    else if (el_off >= 17'd36000) cangle = 16'(el_off - 17'd36000);
    else cangle = 16'(el_off);
  end

  assign cstart = (st_r == ST_REDUCE);

  lp2c_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .start(cstart), .angle(cangle), .done(cdone),
    .sin_out(csin), .cos_out(ccos)
  );

  // One shared multiplier; operands picked by the step.
  always_comb begin
    case (st_r)
      ST_MUL_RC: begin mul_a = 37'(r_s); mul_b = ce_r; end
      ST_MUL_X:  begin mul_a = rc_r;     mul_b = sa_r; end
      ST_MUL_Y:  begin mul_a = rc_r;     mul_b = ca_r; end
      ST_MUL_Z:  begin mul_a = 37'(r_s); mul_b = se_r; end
      default:   begin mul_a = '0;       mul_b = '0;   end
    endcase
  end
  assign mul_res = 57'(mul_a) * 57'(mul_b);

  function automatic logic signed [POS_W-1:0] clamp(input logic signed [56:0] v);
    if (v > 57'sd8388608) clamp = 25'sd8388608;
    else if (v < -57'sd8388608) clamp = -25'sd8388608;
    else clamp = v[POS_W-1:0];
  endfunction

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: ;
      ST_REDUCE: st_nxt = ST_THETA;
      ST_THETA: if (cdone) st_nxt = el_pass_r ? ST_MUL_RC : ST_REDUCE;
      ST_MUL_RC: st_nxt = ST_MUL_X;
      ST_MUL_X: st_nxt = ST_MUL_Y;
      ST_MUL_Y: st_nxt = ST_MUL_Z;
      ST_MUL_Z: st_nxt = ST_EMIT_PT;
      ST_EMIT_PT: if (out_fire) st_nxt = mk_r ? ST_EMIT_MK : ST_IDLE;
      ST_EMIT_MK: if (out_fire) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
    // Advance to the conversion when the accepted byte closes a record.
    if (st_r == ST_IDLE && in_fire) begin
      if (nx_pt) st_nxt = ST_REDUCE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  // Parser decisions for the byte on the input port.
  always_comb begin
    nx_pt = 1'b0;
    nx_mode = mode_r;
    nx_pos = pos_r;
    nx_fill = fill_r;
    if (pos_r < PW'(MAX_PACKET_BYTES)) begin
      nx_pos = pos_r + 1'b1;
      case (mode_r)
        HDR_FIRST: begin
          if (in_byte_value == CHAR_E) nx_mode = HDR_TAG;
          else begin nx_mode = HDR_REC; nx_fill = 3'd1; end
        end
        HDR_TAG: begin
          if (pos_r < PW'(6) && in_byte_value != tag_char(pos_r[2:0])) nx_mode = HDR_DROP;
          else if (pos_r >= PW'(9)) nx_mode = HDR_REC;
        end
        HDR_REC: begin
          if (fill_r < 3'd7) nx_fill = fill_r + 3'd1;
          else begin nx_pt = 1'b1; nx_fill = 3'd0; end
        end
        default: ;
      endcase
    end
    cnt_after = (nx_pt && count_r != COUNT_MAX) ? count_r + 1'b1 : count_r;
    valid_end = (nx_mode == HDR_REC) || (nx_mode == HDR_TAG && nx_pos >= PW'(6));
    nx_mk = in_last_byte && valid_end && (cnt_after > thresh_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= HDR_FIRST;
      pos_r <= '0;
      fill_r <= '0;
      count_r <= '0;
      thresh_r <= THRESH_RESET;
      mk_r <= 1'b0;
      el_pass_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) thresh_r <= cfg_cloud_threshold;
      if (in_fire) begin
        mk_r <= nx_mk;
        lastb_r <= in_byte_value;
        count_r <= nx_mk ? '0 : cnt_after;
        el_pass_r <= 1'b0;
        if (nx_pt) y_r <= '0;
        if (pos_r < PW'(MAX_PACKET_BYTES) && nx_mode == HDR_REC && !nx_pt &&
            (mode_r == HDR_FIRST || mode_r == HDR_REC))
          rec_r[(mode_r == HDR_FIRST) ? 3'd0 : fill_r] <= in_byte_value;
        if (in_last_byte) begin
          mode_r <= HDR_FIRST; pos_r <= '0; fill_r <= '0;
        end else begin
          mode_r <= nx_mode; pos_r <= nx_pos; fill_r <= nx_fill;
        end
        // The point count reported is the count including this point.
        out_cloud_points <= cnt_after;
      end
      if (st_r == ST_THETA && cdone) begin
        if (!el_pass_r) begin sa_r <= csin; ca_r <= ccos; el_pass_r <= 1'b1; end
        else begin se_r <= csin; ce_r <= ccos; end
      end
      if (st_r == ST_MUL_RC) rc_r <= mul_res[36:0];
      if (st_r == ST_MUL_X) x_r <= clamp((mul_res + 57'sd8388608) >>> 24);
      if (st_r == ST_MUL_Y) y_r <= clamp((mul_res + 57'sd8388608) >>> 24);
      if (st_r == ST_MUL_Z) z_r <= clamp((mul_res + 57'sd128) >>> 8);
    end
  end

  // Marker-only bytes are emitted from the idle state via a pending flag.
  always_ff @(posedge clk) begin
    if (!rst_n) mk_only_r <= 1'b0;
    else if (in_fire) mk_only_r <= nx_mk && !nx_pt;
    else if (out_fire && st_r == ST_IDLE) mk_only_r <= 1'b0;
  end

  logic emit_mk;
  assign emit_mk = (st_r == ST_EMIT_MK) || (st_r == ST_IDLE && mk_only_r);
  assign out_valid = (st_r == ST_EMIT_PT) || emit_mk;
  assign out_kind = emit_mk;
  assign out_x_pos = emit_mk ? '0 : x_r;
  assign out_y_pos = emit_mk ? '0 : y_r;
  assign out_z_pos = emit_mk ? '0 : z_r;
  assign out_intensity = emit_mk ? 16'd0 : {rec_r[6], lastb_r};
  assign out_run_last = emit_mk ? 1'b1 : !mk_r;

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> !in_ready) else $error("accepting while busy");
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_x_pos == '0 && out_intensity == 16'd0)
    else $error("marker carries data");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 3'd7) else $error("fill overflow");
`endif

endmodule
